@@ src/ck_pkg.sv @@
// ----------------------------------------------------------------------------
// ck_pkg
// Shared constants and types for the chroma key and pixel placement block.
// ----------------------------------------------------------------------------
`default_nettype none

package ck_pkg;

  // Fixed design constants
  localparam int SAT_THRESHOLD   = 3;
  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int HUE_FRAC_BITS   = 6;

  // Hue scaling
  localparam int HUE_ONE  = 1 << HUE_FRAC_BITS;
  localparam int HUE_SEXT = 60 * HUE_ONE;     // sixty degrees
  localparam int HUE_G    = 120 * HUE_ONE;    // green sector base
  localparam int HUE_B    = 240 * HUE_ONE;    // blue sector base
  localparam int HUE_FULL = 360 * HUE_ONE;
  localparam int HUE_W    = $clog2(HUE_FULL + 1);
  localparam int HUE_SW   = HUE_W + 2;        // signed working width

  // Pipelined divider: quotient never exceeds sixty degrees
  localparam int QUOT_BITS      = $clog2(HUE_SEXT + 1);
  localparam int DIV_BITS       = 4;
  localparam int DIV_STAGES_MIN = (QUOT_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_STAGES     = (DIV_STAGES_MIN < 3) ? 3 : DIV_STAGES_MIN;
  localparam int DIV_QW         = DIV_STAGES * DIV_BITS;
  localparam int DIV_NW         = DIV_QW + 8;

  // Latencies
  localparam int HUE_LAT      = DIV_STAGES + 2;  // front, divider, finalize
  localparam int PLACE_STAGES = 5;
  localparam int OUT_LAT      = HUE_LAT + 1;

  // Compare widths
  localparam int TOL_W  = 9 + HUE_FRAC_BITS;
  localparam int CMP_A  = (HUE_W > TOL_W) ? HUE_W : TOL_W;
  localparam int CMP_W  = ((CMP_A > 15) ? CMP_A : 15) + 2;
  localparam int SAT_W  = 17;

  // Rotation widths
  localparam int COORD_BITS_PORT_W = 12;
  localparam int XS_W  = COORD_BITS_PORT_W + 1;
  localparam int PROD_W = 29;
  localparam int SUM_W  = 30;
  localparam logic [11:0] COORD_MASK =
    (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_HUE       = 3'd0,
    REG_HUE_TOLERANCE = 3'd1,
    REG_ROT_COS       = 3'd2,
    REG_ROT_SIN       = 3'd3,
    REG_PLACE_X       = 3'd4,
    REG_PLACE_Y       = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } cfg_reg_t;

  // Hue sector of the largest component
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Side data traveling with the divider
  typedef struct packed {
    logic    grey;
    logic    neg;
    sector_t sector;
    logic    sat;
  } hue_side_t;

  // Placement result
  typedef struct packed {
    logic signed [14:0] dx;
    logic signed [14:0] dy;
    logic               inb;
    logic [23:0]        addr;
  } place_t;

endpackage

`default_nettype wire

@@ src/ck_div.sv @@
// ----------------------------------------------------------------------------
// ck_div
// Pipelined restoring divider, DIV_BITS quotient bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ck_div
  import ck_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [7:0]        divisor,
  input  wire hue_side_t         side_in,
  output logic [DIV_QW-1:0]      quot,
  output logic [7:0]             rem,
  output hue_side_t              side_out
);

  // Several restoring steps on one partial remainder
  function automatic logic [DIV_QW+7:0] div_step(input logic [7:0] r_in,
                                                 input logic [DIV_QW-1:0] w_in,
                                                 input logic [7:0] d);
    logic [7:0]        r;
    logic [DIV_QW-1:0] w;
    logic [8:0]        t;
    logic              qb;
    r = r_in;
    w = w_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {r, w[DIV_QW-1]};
      qb = (t >= {1'b0, d});
      r  = qb ? 8'(t - {1'b0, d}) : t[7:0];
      w  = {w[DIV_QW-2:0], qb};
    end
    return {r, w};
  endfunction

  logic [7:0]        rem_s  [DIV_STAGES+1];
  logic [DIV_QW-1:0] work_s [DIV_STAGES+1];
  logic [7:0]        d_s    [DIV_STAGES+1];
  hue_side_t         side_s [DIV_STAGES+1];

  // Stage zero: high dividend bits preload the remainder (below any nonzero divisor)
  assign rem_s[0]  = dividend[DIV_NW-1:DIV_QW];
  assign work_s[0] = dividend[DIV_QW-1:0];
  assign d_s[0]    = divisor;
  assign side_s[0] = side_in;

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      {rem_s[k], work_s[k]} <= div_step(rem_s[k-1], work_s[k-1], d_s[k-1]);
      d_s[k]    <= d_s[k-1];
      side_s[k] <= side_s[k-1];
    end
  end

  assign quot     = work_s[DIV_STAGES];
  assign rem      = rem_s[DIV_STAGES];
  assign side_out = side_s[DIV_STAGES];

endmodule

`default_nettype wire

@@ src/ck_hue.sv @@
// ----------------------------------------------------------------------------
// ck_hue
// Hue and saturation of one pixel: front stage, divider, hue finalize.
// ----------------------------------------------------------------------------
`default_nettype none

module ck_hue
  import ck_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  output logic [HUE_W-1:0]      hue,
  output logic                  sat
);

  logic [7:0]        mx, mn, nabs;
  logic [8:0]        sum, den;
  logic              neg, grey;
  sector_t           sector;
  logic [SAT_W-1:0]  sat_l, sat_r;

  logic [DIV_NW-1:0] dvd;
  logic [7:0]        dvs;
  hue_side_t         side_f;

  logic [DIV_QW-1:0] quot;
  logic [7:0]        rem;
  hue_side_t         side_d;

  // Front: max/min with ties to red then green, signed numerator
  always_comb begin
    grey = (red == green) && (green == blue);
    if (red >= green && red >= blue) begin
      sector = SEC_RED;
      mx     = red;
      mn     = (green < blue) ? green : blue;
      neg    = green < blue;
      nabs   = neg ? 8'(blue - green) : 8'(green - blue);
    end else if (green >= blue) begin
      sector = SEC_GREEN;
      mx     = green;
      mn     = (blue < red) ? blue : red;
      neg    = blue < red;
      nabs   = neg ? 8'(red - blue) : 8'(blue - red);
    end else begin
      sector = SEC_BLUE;
      mx     = blue;
      mn     = (red < green) ? red : green;
      neg    = red < green;
      nabs   = neg ? 8'(green - red) : 8'(red - green);
    end
    sum   = {1'b0, mx} + {1'b0, mn};
    den   = sum[8] ? sum : 9'(9'd510 - sum);
    sat_l = SAT_W'(8'(mx - mn)) * SAT_W'(100);
    sat_r = SAT_W'(den) * SAT_W'(SAT_THRESHOLD);
  end

  // Front register
  always_ff @(posedge clk) begin
    dvd         <= DIV_NW'(nabs) * DIV_NW'(HUE_SEXT);
    dvs         <= 8'(mx - mn);
    side_f.grey   <= grey;
    side_f.neg    <= neg;
    side_f.sector <= sector;
    side_f.sat    <= sat_l > sat_r;
  end

  ck_div u_div (
    .clk      (clk),
    .dividend (dvd),
    .divisor  (dvs),
    .side_in  (side_f),
    .quot     (quot),
    .rem      (rem),
    .side_out (side_d)
  );

  // Finalize: floor for negative numerators, sector base, wrap nonpositive, grey to zero
  logic signed [HUE_SW-1:0] qv, hv, hb;
  always_comb begin
    qv = HUE_SW'(quot);
    if (side_d.neg) begin
      hv = -(qv + HUE_SW'(rem != 8'd0));
    end else begin
      hv = qv;
    end
    case (side_d.sector)
      SEC_GREEN: hb = hv + HUE_SW'(HUE_G);
      SEC_BLUE:  hb = hv + HUE_SW'(HUE_B);
      default:   hb = hv;
    endcase
    if (hb <= 0) begin
      hb = hb + HUE_SW'(HUE_FULL);
    end
    if (side_d.grey) begin
      hb = '0;
    end
  end

  always_ff @(posedge clk) begin
    hue <= HUE_W'(hb);
    sat <= side_d.sat;
  end

endmodule

`default_nettype wire

@@ src/ck_place.sv @@
// ----------------------------------------------------------------------------
// ck_place
// Rotation, offset, saturation, bounds check and linear address.
// ----------------------------------------------------------------------------
`default_nettype none

module ck_place
  import ck_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [11:0]        src_x,
  input  wire logic [11:0]        src_y,
  input  wire logic signed [15:0] rot_cos,
  input  wire logic signed [15:0] rot_sin,
  input  wire logic signed [13:0] place_x,
  input  wire logic signed [13:0] place_y,
  input  wire logic [12:0]        canvas_width,
  input  wire logic [12:0]        canvas_height,
  output place_t                  place
);

  localparam int PAD = HUE_LAT - PLACE_STAGES;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'((1 << ANGLE_FRAC_BITS) - 1);

  logic signed [12:0]       xs, ys;
  logic signed [PROD_W-1:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [SUM_W-1:0]  sx, sy, rx, ry, vx, vy;
  logic signed [14:0]       dx3, dy3, dx4, dy4;
  logic                     inb4;
  logic [26:0]              prod4;
  place_t                   res;

  assign xs = 13'(src_x & COORD_MASK);
  assign ys = 13'(src_y & COORD_MASK);

  // Stage 1: products
  always_ff @(posedge clk) begin
    p_xc <= PROD_W'(xs) * PROD_W'(rot_cos);
    p_ys <= PROD_W'(ys) * PROD_W'(rot_sin);
    p_yc <= PROD_W'(ys) * PROD_W'(rot_cos);
    p_xs <= PROD_W'(xs) * PROD_W'(rot_sin);
  end

  // Stage 2: sums, truncate toward zero
  always_comb begin
    sx = SUM_W'(p_xc) + SUM_W'(p_ys);
    sy = SUM_W'(p_yc) - SUM_W'(p_xs);
    if (sx < 0) sx = sx + RND;
    if (sy < 0) sy = sy + RND;
  end

  always_ff @(posedge clk) begin
    rx <= sx >>> ANGLE_FRAC_BITS;
    ry <= sy >>> ANGLE_FRAC_BITS;
  end

  // Stage 3: offset and clamp to 15 bits
  always_comb begin
    vx = rx + SUM_W'(place_x);
    vy = ry + SUM_W'(place_y);
  end

  always_ff @(posedge clk) begin
    if (vx > SUM_W'(16383))       dx3 <= 15'sd16383;
    else if (vx < -SUM_W'(16384)) dx3 <= -15'sd16384;
    else                          dx3 <= vx[14:0];
    if (vy > SUM_W'(16383))       dy3 <= 15'sd16383;
    else if (vy < -SUM_W'(16384)) dy3 <= -15'sd16384;
    else                          dy3 <= vy[14:0];
  end

  // Stage 4: bounds and row product
  always_ff @(posedge clk) begin
    dx4   <= dx3;
    dy4   <= dy3;
    inb4  <= !dx3[14] && !dy3[14] &&
             (dx3[13:0] < 14'(canvas_width)) && (dy3[13:0] < 14'(canvas_height));
    prod4 <= 27'(dy3[13:0]) * 27'(canvas_width);
  end

  // Stage 5: address
  always_ff @(posedge clk) begin
    res.dx   <= dx4;
    res.dy   <= dy4;
    res.inb  <= inb4;
    res.addr <= 24'(27'(dx4[13:0]) + prod4);
  end

  // Align with the hue path
  if (PAD > 0) begin : g_pad
    place_t dly [PAD];
    always_ff @(posedge clk) begin
      dly[0] <= res;
      for (int i = 1; i < PAD; i++) begin
        dly[i] <= dly[i-1];
      end
    end
    assign place = dly[PAD-1];
  end else begin : g_nopad
    assign place = res;
  end

endmodule

`default_nettype wire

@@ src/chroma_key_place_pixel.sv @@
// Throughput: one pixel per clock; busy stays low, the receiver cannot stall.
// Depth is set by the pipelined hue divider, four quotient bits per stage.
// Reset (rst, synchronous) clears the valid pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// chroma_key_place_pixel
// Chroma key test and rotated placement of one foreground pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_key_place_pixel
  import ck_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [11:0] src_x,
  input  wire logic [11:0] src_y,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             done,
  output logic             write_enable,
  output logic             is_key,
  output logic [14:0]      dest_x,
  output logic [14:0]      dest_y,
  output logic [23:0]      dest_address,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);

  logic [14:0]        key_hue;
  logic [8:0]         hue_tolerance;
  logic signed [15:0] rot_cos, rot_sin;
  logic signed [13:0] place_x, place_y;
  logic [12:0]        canvas_width, canvas_height;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_hue       <= 15'd7680;
      hue_tolerance <= 9'd33;
      rot_cos       <= 16'sd16384;
      rot_sin       <= '0;
      place_x       <= '0;
      place_y       <= '0;
      canvas_width  <= 13'd4096;
      canvas_height <= 13'd4096;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_HUE:       key_hue       <= cfg_data[14:0];
        REG_HUE_TOLERANCE: hue_tolerance <= cfg_data[8:0];
        REG_ROT_COS:       rot_cos       <= cfg_data;
        REG_ROT_SIN:       rot_sin       <= cfg_data;
        REG_PLACE_X:       place_x       <= cfg_data[13:0];
        REG_PLACE_Y:       place_y       <= cfg_data[13:0];
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[12:0];
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Valid bits and color travel alongside the hue path
  logic       vld  [HUE_LAT];
  logic [23:0] rgb [HUE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HUE_LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < HUE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    rgb[0] <= {red, green, blue};
    for (int i = 1; i < HUE_LAT; i++) rgb[i] <= rgb[i-1];
  end

  logic [HUE_W-1:0] hue;
  logic             sat;
  place_t           place;

  ck_hue u_hue (
    .clk   (clk),
    .red   (red),
    .green (green),
    .blue  (blue),
    .hue   (hue),
    .sat   (sat)
  );

  ck_place u_place (
    .clk           (clk),
    .src_x         (src_x),
    .src_y         (src_y),
    .rot_cos       (rot_cos),
    .rot_sin       (rot_sin),
    .place_x       (place_x),
    .place_y       (place_y),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .place         (place)
  );

  // Key band test, strict on both sides, no wrap, gated by saturation
  logic signed [CMP_W-1:0] kh, hu, tol, dif;
  logic                    key;
  always_comb begin
    kh  = CMP_W'(key_hue);
    hu  = CMP_W'(hue);
    tol = CMP_W'(hue_tolerance) * CMP_W'(HUE_ONE);
    dif = kh - hu;
    key = (dif < tol) && (dif > -tol) && sat;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[HUE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    is_key       <= key;
    write_enable <= !key && place.inb;
    dest_x       <= key ? 15'd0 : place.dx;
    dest_y       <= key ? 15'd0 : place.dy;
    dest_address <= (!key && place.inb) ? place.addr : 24'd0;
    {out_red, out_green, out_blue} <= rgb[HUE_LAT-1];
  end

endmodule

`default_nettype wire

@@ src/ck_check.sv @@
// ----------------------------------------------------------------------------
// ck_check
// Port-level checks for the chroma key block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ck_check
  import ck_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        write_enable,
  input wire logic        is_key,
  input wire logic [14:0] dest_x,
  input wire logic [14:0] dest_y,
  input wire logic [23:0] dest_address
);

  // Every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##OUT_LAT done)
    else $error("beat did not complete on time");

  // A keyed pixel is never written and has zero destination
  a_key: assert property (@(posedge clk) disable iff (rst)
    (done && is_key) |-> (!write_enable && dest_x == 15'd0 && dest_y == 15'd0))
    else $error("keyed pixel not cleared");

  // No address without a write
  a_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !write_enable) |-> (dest_address == 24'd0))
    else $error("address without write");

  // A written pixel lands at nonnegative coordinates
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (done && write_enable) |-> (!dest_x[14] && !dest_y[14]))
    else $error("write at negative coordinate");

endmodule

bind chroma_key_place_pixel ck_check u_ck_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .write_enable (write_enable),
  .is_key       (is_key),
  .dest_x       (dest_x),
  .dest_y       (dest_y),
  .dest_address (dest_address)
);

`default_nettype wire
